/* rtl/gpl_pkg.sv */
`timescale 1ns / 1ps
package gpl_pkg;

    localparam int ColWidth   = 10;
    localparam int CountWidth = 16;
    localparam int SumWidth   = 26;
    localparam int QueueDepth = 2;

    localparam logic [2:0] RegImageWidth    = 3'd0;
    localparam logic [2:0] RegMinYellow     = 3'd1;
    localparam logic [2:0] RegMinPostGap    = 3'd2;
    localparam logic [2:0] RegMinSplitCount = 3'd3;
    localparam logic [2:0] RegRedMin        = 3'd4;
    localparam logic [2:0] RegGreenMin      = 3'd5;
    localparam logic [2:0] RegBlueMax       = 3'd6;

    typedef struct packed {
        logic [10:0] image_width;
        logic [15:0] min_yellow_count;
        logic [9:0]  min_post_gap;
        logic [15:0] min_split_count;
        logic [7:0]  red_min;
        logic [7:0]  green_min;
        logic [7:0]  blue_max;
    } t_cfg;

    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic [SumWidth-1:0]   sum;
        logic [SumWidth-1:0]   left_sum;
        logic [CountWidth-1:0] left_count;
        logic [ColWidth-1:0]   widest_gap;
    } t_frame_sum;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_DIV_FIRST,
        BK_DIV_SECOND,
        BK_DONE
    } t_back_state;

endpackage

/* rtl/gpl_pix_if.sv */
`timescale 1ns / 1ps
interface gpl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] column;
    logic       frame_end;

    modport source(output valid, red, green, blue, column, frame_end, input ready);
    modport sink(input valid, red, green, blue, column, frame_end, output ready);
endinterface

/* rtl/gpl_res_if.sv */
`timescale 1ns / 1ps
interface gpl_res_if;
    logic        valid;
    logic        ready;
    logic        goal_seen;
    logic        two_posts;
    logic [9:0]  left_column;
    logic [9:0]  right_column;
    logic [9:0]  middle_column;
    logic [15:0] yellow_count;

    modport source(output valid, goal_seen, two_posts, left_column, right_column,
                   middle_column, yellow_count, input ready);
    modport sink(input valid, goal_seen, two_posts, left_column, right_column,
                 middle_column, yellow_count, output ready);
endinterface

/* rtl/gpl_front.sv */
`timescale 1ns / 1ps
module gpl_front #(
    parameter int MAX_SAMPLES = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpl_pkg::t_cfg       i_cfg,
    gpl_pix_if.sink             i_pix,
    input  logic                i_q_full,
    output logic                o_push,
    output gpl_pkg::t_frame_sum o_push_data
);

    localparam int CountLimit = (MAX_SAMPLES > 65535) ? 65535 : MAX_SAMPLES;

    logic [gpl_pkg::ColWidth-1:0]   r_prev;
    logic                           r_have_prev;
    logic [gpl_pkg::SumWidth-1:0]   r_sum;
    logic [gpl_pkg::CountWidth-1:0] r_count;
    logic [gpl_pkg::ColWidth-1:0]   r_gap;
    logic [gpl_pkg::SumWidth-1:0]   r_left_sum;
    logic [gpl_pkg::CountWidth-1:0] r_left_count;

    logic [gpl_pkg::ColWidth-1:0]   n_prev;
    logic                           n_have_prev;
    logic [gpl_pkg::SumWidth-1:0]   n_sum;
    logic [gpl_pkg::CountWidth-1:0] n_count;
    logic [gpl_pkg::ColWidth-1:0]   n_gap;
    logic [gpl_pkg::SumWidth-1:0]   n_left_sum;
    logic [gpl_pkg::CountWidth-1:0] n_left_count;

    logic                           accept;
    logic                           yellow;
    logic [gpl_pkg::ColWidth-1:0]   gap;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && !i_q_full;

    assign yellow = (i_pix.red > i_cfg.red_min) && (i_pix.green > i_cfg.green_min)
                    && (i_pix.blue < i_cfg.blue_max)
                    && (r_count < gpl_pkg::CountWidth'(CountLimit));
    assign gap    = (i_pix.column >= r_prev) ? (i_pix.column - r_prev) : '0;

    always_comb begin
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_sum        = r_sum;
        n_count      = r_count;
        n_gap        = r_gap;
        n_left_sum   = r_left_sum;
        n_left_count = r_left_count;
        if (yellow) begin
            if (r_have_prev && (gap > r_gap)) begin
                n_gap        = gap;
                n_left_sum   = r_sum;
                n_left_count = r_count;
            end
            n_prev      = i_pix.column;
            n_have_prev = 1'b1;
            n_sum       = r_sum + gpl_pkg::SumWidth'(i_pix.column);
            n_count     = r_count + 16'd1;
        end
    end

    assign o_push                 = accept && i_pix.frame_end;
    assign o_push_data.count      = n_count;
    assign o_push_data.sum        = n_sum;
    assign o_push_data.left_sum   = n_left_sum;
    assign o_push_data.left_count = n_left_count;
    assign o_push_data.widest_gap = n_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_have_prev  <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_gap        <= '0;
            r_left_sum   <= '0;
            r_left_count <= '0;
        end else if (accept) begin
            if (i_pix.frame_end) begin
                r_prev       <= '0;
                r_have_prev  <= 1'b0;
                r_sum        <= '0;
                r_count      <= '0;
                r_gap        <= '0;
                r_left_sum   <= '0;
                r_left_count <= '0;
            end else begin
                r_prev       <= n_prev;
                r_have_prev  <= n_have_prev;
                r_sum        <= n_sum;
                r_count      <= n_count;
                r_gap        <= n_gap;
                r_left_sum   <= n_left_sum;
                r_left_count <= n_left_count;
            end
        end
    end

endmodule

/* rtl/gpl_queue.sv */
`timescale 1ns / 1ps
module gpl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gpl_pkg::t_frame_sum i_push_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output gpl_pkg::t_frame_sum o_data
);

    gpl_pkg::t_frame_sum r_mem [gpl_pkg::QueueDepth];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_cnt;

    assign o_full  = (r_cnt == 2'(gpl_pkg::QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'(gpl_pkg::QueueDepth)) || i_pop)
        else $error("Frame summary written into a full queue.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("Frame summary taken from an empty queue.");
`endif

endmodule

/* rtl/gpl_div.sv */
`timescale 1ns / 1ps
module gpl_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [gpl_pkg::SumWidth-1:0]   i_dividend,
    input  logic [gpl_pkg::CountWidth-1:0] i_divisor,
    output logic                           o_done,
    output logic [gpl_pkg::ColWidth-1:0]   o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [3:0]                     r_step;
    logic [gpl_pkg::CountWidth-1:0] r_rem;
    logic [gpl_pkg::CountWidth-1:0] r_dvs;
    logic [gpl_pkg::ColWidth-1:0]   r_q;

    logic [gpl_pkg::CountWidth:0]   trial;
    logic                           fits;

    // The quotient is a mean column and so always fits in ten bits.
    assign trial = {r_rem, r_q[gpl_pkg::ColWidth-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[gpl_pkg::SumWidth-1:gpl_pkg::ColWidth];
            r_q   <= i_dividend[gpl_pkg::ColWidth-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? gpl_pkg::CountWidth'(trial - {1'b0, r_dvs})
                          : trial[gpl_pkg::CountWidth-1:0];
            r_q   <= {r_q[gpl_pkg::ColWidth-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'(gpl_pkg::ColWidth - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/gpl_back.sv */
`timescale 1ns / 1ps
module gpl_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpl_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  gpl_pkg::t_frame_sum i_q_data,
    output logic                o_q_pop,
    gpl_res_if.source           o_res
);

    localparam logic [12:0] WidthCap = 13'(MAX_WIDTH);

    gpl_pkg::t_back_state r_state;
    gpl_pkg::t_back_state n_state;

    gpl_pkg::t_frame_sum  r_rec;
    logic                 r_seen;
    logic                 r_two;
    logic [9:0]           r_lc;
    logic [9:0]           r_rc;

    logic                 r_out_valid;
    logic                 r_out_seen;
    logic                 r_out_two;
    logic [9:0]           r_out_left;
    logic [9:0]           r_out_right;
    logic [9:0]           r_out_mid;
    logic [15:0]          r_out_count;

    logic [12:0]          width_eff;
    logic [11:0]          half_wide;
    logic [9:0]           half;
    logic                 c_seen;
    logic                 c_nonzero;
    logic                 c_two;
    logic                 load_out;
    logic [10:0]          mid_sum;

    logic                 div_start;
    logic [gpl_pkg::SumWidth-1:0]   div_dividend;
    logic [gpl_pkg::CountWidth-1:0] div_divisor;
    logic                 div_done;
    logic [9:0]           div_q;

    assign width_eff = ({2'b00, i_cfg.image_width} > WidthCap) ? WidthCap
                                                              : {2'b00, i_cfg.image_width};
    assign half_wide = width_eff[12:1];
    assign half      = (half_wide > 12'd1023) ? 10'd1023 : half_wide[9:0];

    assign c_seen    = (r_rec.count >= i_cfg.min_yellow_count);
    assign c_nonzero = (r_rec.count != '0);
    assign c_two     = (r_rec.widest_gap != '0)
                       && (r_rec.widest_gap >= i_cfg.min_post_gap)
                       && (r_rec.count >= i_cfg.min_split_count)
                       && (r_rec.left_count != '0)
                       && (r_rec.left_count < r_rec.count);

    assign load_out = (r_state == gpl_pkg::BK_DONE) && (!r_out_valid || o_res.ready);
    assign mid_sum  = {1'b0, r_lc} + {1'b0, r_rc};

    gpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpl_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_rec.sum;
        div_divisor  = r_rec.count;
        case (r_state)
            gpl_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = gpl_pkg::BK_CHECK;
                end
            end
            gpl_pkg::BK_CHECK: begin
                if (c_seen && c_nonzero) begin
                    div_start = 1'b1;
                    if (c_two) begin
                        div_dividend = r_rec.left_sum;
                        div_divisor  = r_rec.left_count;
                    end
                    n_state = gpl_pkg::BK_DIV_FIRST;
                end else begin
                    n_state = gpl_pkg::BK_DONE;
                end
            end
            gpl_pkg::BK_DIV_FIRST: begin
                if (div_done) begin
                    if (r_two) begin
                        div_start    = 1'b1;
                        div_dividend = r_rec.sum - r_rec.left_sum;
                        div_divisor  = r_rec.count - r_rec.left_count;
                        n_state      = gpl_pkg::BK_DIV_SECOND;
                    end else begin
                        n_state = gpl_pkg::BK_DONE;
                    end
                end
            end
            gpl_pkg::BK_DIV_SECOND: begin
                if (div_done) begin
                    n_state = gpl_pkg::BK_DONE;
                end
            end
            gpl_pkg::BK_DONE: begin
                if (load_out) begin
                    n_state = gpl_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = gpl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end
        if (r_state == gpl_pkg::BK_CHECK) begin
            r_seen <= c_seen;
            r_two  <= c_seen && c_nonzero && c_two;
            r_lc   <= half;
            r_rc   <= half;
        end else if ((r_state == gpl_pkg::BK_DIV_FIRST) && div_done) begin
            r_lc <= div_q;
            r_rc <= div_q;
        end else if ((r_state == gpl_pkg::BK_DIV_SECOND) && div_done) begin
            r_rc <= div_q;
        end
        if (load_out) begin
            r_out_seen  <= r_seen;
            r_out_two   <= r_two;
            r_out_left  <= r_lc;
            r_out_right <= r_rc;
            r_out_mid   <= mid_sum[10:1];
            r_out_count <= r_rec.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.goal_seen     = r_out_seen;
    assign o_res.two_posts     = r_out_two;
    assign o_res.left_column   = r_out_left;
    assign o_res.right_column  = r_out_right;
    assign o_res.middle_column = r_out_mid;
    assign o_res.yellow_count  = r_out_count;

`ifndef NO_ASSERTIONS
    a_two_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.two_posts |-> o_res.goal_seen)
        else $error("Two posts reported without the goal being seen.");
    a_unseen_centred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.goal_seen |->
            (o_res.left_column == o_res.right_column)
            && (o_res.middle_column == o_res.left_column))
        else $error("Unseen goal reported with differing columns.");
    a_mid_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.left_column <= o_res.right_column) |->
            (o_res.middle_column >= o_res.left_column)
            && (o_res.middle_column <= o_res.right_column))
        else $error("Middle column lies outside the two posts.");
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == gpl_pkg::BK_DIV_FIRST)
                     || (r_state == gpl_pkg::BK_DIV_SECOND))
        else $error("Divider finished while no quotient was awaited.");
`endif

endmodule

/* rtl/goal_post_pair_locator_unit.sv */
`timescale 1ns / 1ps
// Pixel words are taken one per cycle and accumulated on the fly; any word
// stalls while the two-entry summary queue is full, which a run of short
// frames or a result output held not ready can cause. Each frame summary is
// then resolved by a shared ten-step restoring divider: a frame with no goal
// or no yellow samples skips it, a single-post frame uses it once and a
// two-post frame twice, so frames shorter than the back end's work sustain
// one pixel per cycle only while the queue absorbs the difference.
module goal_post_pair_locator_unit #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_SAMPLES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpl_pix_if.sink     i_pix,
    gpl_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gpl_pkg::t_cfg       r_cfg;
    logic                q_full;
    logic                q_push;
    gpl_pkg::t_frame_sum q_push_data;
    logic                q_pop;
    logic                q_valid;
    gpl_pkg::t_frame_sum q_data;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= 11'd320;
            r_cfg.min_yellow_count <= 16'd20;
            r_cfg.min_post_gap     <= 10'd22;
            r_cfg.min_split_count  <= 16'd30;
            r_cfg.red_min          <= 8'd175;
            r_cfg.green_min        <= 8'd175;
            r_cfg.blue_max         <= 8'd130;
        end else if (cfg_write) begin
            case (paddr[4:2])
                gpl_pkg::RegImageWidth:    r_cfg.image_width      <= pwdata[10:0];
                gpl_pkg::RegMinYellow:     r_cfg.min_yellow_count <= pwdata[15:0];
                gpl_pkg::RegMinPostGap:    r_cfg.min_post_gap     <= pwdata[9:0];
                gpl_pkg::RegMinSplitCount: r_cfg.min_split_count  <= pwdata[15:0];
                gpl_pkg::RegRedMin:        r_cfg.red_min          <= pwdata[7:0];
                gpl_pkg::RegGreenMin:      r_cfg.green_min        <= pwdata[7:0];
                gpl_pkg::RegBlueMax:       r_cfg.blue_max         <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gpl_pkg::RegImageWidth:    prdata = {21'd0, r_cfg.image_width};
            gpl_pkg::RegMinYellow:     prdata = {16'd0, r_cfg.min_yellow_count};
            gpl_pkg::RegMinPostGap:    prdata = {22'd0, r_cfg.min_post_gap};
            gpl_pkg::RegMinSplitCount: prdata = {16'd0, r_cfg.min_split_count};
            gpl_pkg::RegRedMin:        prdata = {24'd0, r_cfg.red_min};
            gpl_pkg::RegGreenMin:      prdata = {24'd0, r_cfg.green_min};
            gpl_pkg::RegBlueMax:       prdata = {24'd0, r_cfg.blue_max};
            default:                   prdata = '0;
        endcase
    end

    gpl_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix       (i_pix),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    gpl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    gpl_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

/* tb/sv/goal_report_checker.sv */
`timescale 1ns / 1ps
module goal_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpl_pix_if          i_pix,
    gpl_res_if          i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_reports_due,
    output int          o_reports_seen
);
    import gpl_pkg::*;

    localparam logic [15:0] CountCap = 16'hFFFF;

    typedef struct packed {
        logic        goal_seen;
        logic        two_posts;
        logic [9:0]  left_column;
        logic [9:0]  right_column;
        logic [9:0]  middle_column;
        logic [15:0] yellow_count;
    } t_goal_report;

    t_cfg         settings;
    logic [9:0]   last_yellow_column;
    logic         any_yellow;
    logic [25:0]  column_sum;
    logic [15:0]  yellow_total;
    logic [9:0]   widest_gap;
    logic [25:0]  left_sum;
    logic [15:0]  left_total;
    t_goal_report reports_due[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic clear_frame();
        last_yellow_column = '0;
        any_yellow = 1'b0;
        column_sum = '0;
        yellow_total = '0;
        widest_gap = '0;
        left_sum = '0;
        left_total = '0;
    endtask

    function automatic t_goal_report locate_posts();
        t_goal_report rep;
        int unsigned  half;
        int unsigned  lc;
        int unsigned  rc;
        int unsigned  mc;
        logic         split;
        half = ((settings.image_width > 11'd1024) ? 1024 : int'(settings.image_width)) / 2;
        lc = half;
        rc = half;
        split = 1'b0;
        rep.goal_seen = yellow_total >= settings.min_yellow_count;
        if (rep.goal_seen && yellow_total != 16'd0) begin
            split = widest_gap != 10'd0 && widest_gap >= settings.min_post_gap
                    && yellow_total >= settings.min_split_count
                    && left_total != 16'd0 && left_total < yellow_total;
            if (split) begin
                lc = int'(left_sum) / int'(left_total);
                rc = (int'(column_sum) - int'(left_sum)) / (int'(yellow_total) - int'(left_total));
            end else begin
                lc = int'(column_sum) / int'(yellow_total);
                rc = lc;
            end
        end
        mc = (lc + rc) / 2;
        rep.two_posts = split;
        rep.left_column = lc[9:0];
        rep.right_column = rc[9:0];
        rep.middle_column = mc[9:0];
        rep.yellow_count = yellow_total;
        return rep;
    endfunction

    task automatic absorb_word();
        logic [9:0] gap;
        if (i_pix.red > settings.red_min && i_pix.green > settings.green_min
                && i_pix.blue < settings.blue_max && yellow_total != CountCap) begin
            if (any_yellow) begin
                // A column that goes backwards counts as no gap at all.
                gap = (i_pix.column >= last_yellow_column) ?
                      i_pix.column - last_yellow_column : 10'd0;
                if (gap > widest_gap) begin
                    widest_gap = gap;
                    left_sum = column_sum;
                    left_total = yellow_total;
                end
            end
            last_yellow_column = i_pix.column;
            any_yellow = 1'b1;
            column_sum = column_sum + 26'(i_pix.column);
            yellow_total = yellow_total + 16'd1;
        end
        if (i_pix.frame_end) begin
            reports_due = {reports_due, locate_posts()};
            clear_frame();
        end
    endtask

    task automatic check_report();
        t_goal_report want;
        o_reports_seen++;
        if (reports_due.size() == 0) begin
            report_mismatch($sformatf("frame report (count %0d) with none expected",
                                      i_res.yellow_count));
        end else begin
            want = reports_due.pop_front();
            if (i_res.goal_seen !== want.goal_seen)
                report_mismatch($sformatf("goal_seen %0d, expected %0d",
                                          i_res.goal_seen, want.goal_seen));
            if (i_res.two_posts !== want.two_posts)
                report_mismatch($sformatf("two_posts %0d, expected %0d",
                                          i_res.two_posts, want.two_posts));
            if (i_res.left_column !== want.left_column)
                report_mismatch($sformatf("left_column %0d, expected %0d",
                                          i_res.left_column, want.left_column));
            if (i_res.right_column !== want.right_column)
                report_mismatch($sformatf("right_column %0d, expected %0d",
                                          i_res.right_column, want.right_column));
            if (i_res.middle_column !== want.middle_column)
                report_mismatch($sformatf("middle_column %0d, expected %0d",
                                          i_res.middle_column, want.middle_column));
            if (i_res.yellow_count !== want.yellow_count)
                report_mismatch($sformatf("yellow_count %0d, expected %0d",
                                          i_res.yellow_count, want.yellow_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.image_width = 11'd320;
            settings.min_yellow_count = 16'd20;
            settings.min_post_gap = 10'd22;
            settings.min_split_count = 16'd30;
            settings.red_min = 8'd175;
            settings.green_min = 8'd175;
            settings.blue_max = 8'd130;
            clear_frame();
            reports_due.delete();
            o_mismatches = 0;
            o_reports_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    RegImageWidth:    settings.image_width = pwdata[10:0];
                    RegMinYellow:     settings.min_yellow_count = pwdata[15:0];
                    RegMinPostGap:    settings.min_post_gap = pwdata[9:0];
                    RegMinSplitCount: settings.min_split_count = pwdata[15:0];
                    RegRedMin:        settings.red_min = pwdata[7:0];
                    RegGreenMin:      settings.green_min = pwdata[7:0];
                    RegBlueMax:       settings.blue_max = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                check_report();
            end
            if (i_pix.valid && i_pix.ready) begin
                absorb_word();
            end
        end
        o_reports_due = reports_due.size();
    end

endmodule

/* tb/sv/goal_post_pair_locator_unit_test.sv */
`timescale 1ns / 1ps
module goal_post_pair_locator_unit_test;
    import gpl_pkg::*;

    localparam int SettleCycles = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          reports_due;
    int          reports_seen;
    int          words_sent = 0;
    int          settings_used = 0;
    bit          calm = 1'b0;
    t_cfg        active;

    gpl_pix_if pix ();
    gpl_res_if res ();

    always #6 i_clk = ~i_clk;

    goal_post_pair_locator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    goal_report_checker report_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix),
        .i_res          (res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_reports_due  (reports_due),
        .o_reports_seen (reports_seen)
    );

    task automatic send_word(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [9:0] col, input logic last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red <= r;
        pix.green <= g;
        pix.blue <= b;
        pix.column <= col;
        pix.frame_end <= last;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (reports_due != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        drain();
        write_register(RegImageWidth, 32'(c.image_width));
        write_register(RegMinYellow, 32'(c.min_yellow_count));
        write_register(RegMinPostGap, 32'(c.min_post_gap));
        write_register(RegMinSplitCount, 32'(c.min_split_count));
        write_register(RegRedMin, 32'(c.red_min));
        write_register(RegGreenMin, 32'(c.green_min));
        write_register(RegBlueMax, 32'(c.blue_max));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active = c;
        settings_used++;
    endtask

    function automatic logic [7:0] above(input logic [7:0] floor_v);
        return (floor_v == 8'd255) ? 8'd255 : 8'($urandom_range(int'(floor_v) + 1, 255));
    endfunction

    function automatic logic [7:0] below(input logic [7:0] ceil_v);
        return (ceil_v == 8'd0) ? 8'd0 : 8'($urandom_range(0, int'(ceil_v) - 1));
    endfunction

    function automatic logic [7:0] colour_floor();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        return 8'($urandom_range(0, 230));
    endfunction

    task automatic send_pixel(input bit yellow, input int col, input bit last);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = above(active.red_min);
        g = above(active.green_min);
        b = below(active.blue_max);
        if (!yellow) begin
            case ($urandom_range(0, 3))
                0: r = 8'($urandom_range(0, active.red_min));
                1: g = 8'($urandom_range(0, active.green_min));
                2: b = 8'($urandom_range(active.blue_max, 255));
                default: begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
        end
        send_word(r, g, b, col[9:0], last);
    endtask

    task automatic send_frame(input int samples, input int yellow_in16, input bit scrambled);
        int col;
        col = $urandom_range(0, 700);
        for (int i = 0; i < samples; i++) begin
            if (scrambled)
                col = $urandom_range(0, 1023);
            else if ($urandom_range(0, 9) == 0)
                col += $urandom_range(0, 500);
            else
                col += $urandom_range(0, 2);
            if (col > 1023)
                col = 1023;
            send_pixel($urandom_range(1, 16) <= yellow_in16, col, i == samples - 1);
        end
    endtask

    task automatic random_frame();
        int samples;
        samples = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
        send_frame(samples, $urandom_range(0, 16), $urandom_range(0, 7) == 0);
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        case ($urandom_range(0, 5))
            0: c.image_width = 11'd0;
            1: c.image_width = 11'd1;
            2: c.image_width = 11'd1024;
            3: c.image_width = 11'd2047;
            default: c.image_width = 11'($urandom_range(1, 2047));
        endcase
        case ($urandom_range(0, 4))
            0: c.min_yellow_count = 16'd0;
            1: c.min_yellow_count = 16'd1;
            2: c.min_yellow_count = 16'hFFFF;
            default: c.min_yellow_count = 16'($urandom_range(0, 12));
        endcase
        case ($urandom_range(0, 4))
            0: c.min_post_gap = 10'd0;
            1: c.min_post_gap = 10'd1;
            2: c.min_post_gap = 10'd1023;
            default: c.min_post_gap = 10'($urandom_range(1, 300));
        endcase
        case ($urandom_range(0, 3))
            0: c.min_split_count = 16'd0;
            1: c.min_split_count = 16'hFFFF;
            default: c.min_split_count = 16'($urandom_range(0, 20));
        endcase
        c.red_min = colour_floor();
        c.green_min = colour_floor();
        c.blue_max = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255) :
                                                   8'($urandom_range(25, 255));
        return c;
    endfunction

    initial begin
        res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(negedge i_clk);
            if (!calm) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
        end
    end

    initial begin
        t_cfg c;
        int   phase_words;
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        pix.column = '0;
        pix.frame_end = 1'b0;
        active.image_width = 11'd320;
        active.min_yellow_count = 16'd20;
        active.min_post_gap = 10'd22;
        active.min_split_count = 16'd30;
        active.red_min = 8'd175;
        active.green_min = 8'd175;
        active.blue_max = 8'd130;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
        send_word(8'd255, 8'd255, 8'd255, 10'd1023, 1'b1);

        c = active;
        c.min_yellow_count = 16'd2;
        c.min_split_count = 16'd2;
        apply_settings(c);
        send_word(8'd200, 8'd200, 8'd50, 10'd10, 1'b0);
        send_word(8'd200, 8'd200, 8'd50, 10'd12, 1'b0);
        send_word(8'd200, 8'd200, 8'd50, 10'd100, 1'b0);
        send_word(8'd200, 8'd200, 8'd50, 10'd104, 1'b1);
        // Red or blue exactly on its threshold is not yellow; one step inside is.
        send_word(8'd175, 8'd200, 8'd100, 10'd300, 1'b0);
        send_word(8'd176, 8'd176, 8'd129, 10'd300, 1'b0);
        send_word(8'd200, 8'd200, 8'd130, 10'd301, 1'b0);
        send_word(8'd176, 8'd176, 8'd129, 10'd301, 1'b1);
        send_word(8'd255, 8'd255, 8'd0, 10'd500, 1'b0);
        send_word(8'd255, 8'd255, 8'd0, 10'd200, 1'b0);
        send_word(8'd255, 8'd255, 8'd0, 10'd230, 1'b1);
        send_word(8'd255, 8'd255, 8'd0, 10'd0, 1'b0);
        send_word(8'd255, 8'd255, 8'd0, 10'd50, 1'b0);
        send_word(8'd255, 8'd255, 8'd0, 10'd100, 1'b1);
        send_word(8'd255, 8'd255, 8'd0, 10'd1023, 1'b1);

        c.image_width = 11'd2047;
        c.min_yellow_count = 16'd0;
        c.min_post_gap = 10'd0;
        c.min_split_count = 16'd0;
        c.red_min = 8'd0;
        c.green_min = 8'd0;
        c.blue_max = 8'd255;
        apply_settings(c);
        send_word(8'd1, 8'd1, 8'd254, 10'd5, 1'b0);
        send_word(8'd1, 8'd1, 8'd254, 10'd5, 1'b0);
        send_word(8'd1, 8'd1, 8'd254, 10'd5, 1'b1);
        send_word(8'd0, 8'd0, 8'd0, 10'd7, 1'b1);
        phase_words = words_sent;
        while (words_sent - phase_words < 120) random_frame();

        c.image_width = 11'd1024;
        c.min_yellow_count = 16'hFFFF;
        c.min_post_gap = 10'd1023;
        c.min_split_count = 16'hFFFF;
        c.red_min = 8'd255;
        c.green_min = 8'd255;
        c.blue_max = 8'd0;
        apply_settings(c);
        phase_words = words_sent;
        while (words_sent - phase_words < 30) random_frame();

        for (int p = 0; p < 7; p++) begin
            apply_settings(random_settings());
            phase_words = words_sent;
            if (p == 3) begin
                repeat (3) random_frame();
                drain();
            end
            while (words_sent - phase_words < 120) random_frame();
        end

        apply_settings(random_settings());
        calm = 1'b1;
        phase_words = words_sent;
        while (words_sent - phase_words < 120) random_frame();

        pix.valid <= 1'b0;
        while (reports_due != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        $display("Checked %0d frame reports from %0d pixel words under %0d register settings,",
                 reports_seen, words_sent, settings_used);
        $display("with threshold edges, backward columns, empty frames and extreme settings.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/gpl_pkg.sv
rtl/gpl_pix_if.sv
rtl/gpl_res_if.sv
rtl/gpl_front.sv
rtl/gpl_queue.sv
rtl/gpl_div.sv
rtl/gpl_back.sv
rtl/goal_post_pair_locator_unit.sv
tb/sv/goal_report_checker.sv
tb/sv/goal_post_pair_locator_unit_test.sv
